/* rtl/mlfq_pkg.sv */
package mlfq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned TopLevelDefault   = 3;
  localparam logic [15:0] QuantumReset      = 16'd50;
  localparam logic [15:0] AllotmentReset    = 16'd200;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_BOOST    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_DISPATCH  = 3'd2,
    ST_NOTHING   = 3'd3,
    ST_BOOSTED   = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REG_QUANTUM   = 1'b0,
    REG_ALLOTMENT = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_CHOOSE,
    S_MOD,
    S_SUB,
    S_SHIFT,
    S_WRITE,
    S_BOOST,
    S_DONE
  } state_e;

  // request and reply between the sequencer and the modulo unit
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [16:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } mod_rsp_t;

endpackage

/* rtl/mlfq_mod_unit.sv */
module mlfq_mod_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlfq_pkg::mod_req_t req_i,
  output mlfq_pkg::mod_rsp_t rsp_o
);
  import mlfq_pkg::*;

  logic [16:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] trial;

  // one restoring division step a cycle
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[15]} - {1'b0, req_i.divisor};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
      end else begin
        rem_d = {rem_q[15:0], quo_q[15]};
      end
      quo_d = {quo_q[14:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[15:0];

endmodule

/* rtl/mlfq_job_scheduler.sv */
// multilevel feedback queue job scheduler
// usage: drive command_i and the job fields with start_i high while busy_o
// is low; the item is taken at that edge and busy_o rises the next cycle.
// exactly one result follows per item: done_o is high for one cycle with
// status_o and the job fields valid; busy_o falls at the end of that cycle.
// steps per command: add writes the new entry at the tail; an unknown
// command goes straight to done; boost reads and rewrites each entry in
// turn; dispatch scans one entry a cycle, runs a bit-serial modulo when
// the run is cut by i/o, then moves queue entries one at a time.
// the queue memory port (one read, one write a cycle) sets the scan and
// shift lengths, the modulo unit the cut length.
// configuration: cfg_we_i with cfg_idx_i (0 quantum, 1 allotment) and
// cfg_data_i, written while idle; no read-back.
// reset empties the queue, sets the scan level to the top level and loads
// quantum 50 and allotment 200. queue contents are not cleared.
// the receiver cannot stall: each result is shown for one cycle only.
module mlfq_job_scheduler #(
  parameter int unsigned QUEUE_DEPTH = mlfq_pkg::QueueDepthDefault,
  parameter int unsigned TOP_LEVEL   = mlfq_pkg::TopLevelDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  job_tag_i,
  input  logic [1:0]  job_type_i,
  input  logic [15:0] job_length_i,
  input  logic [6:0]  io_odds_i,
  input  logic [6:0]  io_roll_i,
  input  logic [15:0] io_seed_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [7:0]  out_tag_o,
  output logic [1:0]  out_type_o,
  output logic [15:0] run_time_o,
  output logic [15:0] remaining_o,
  output logic        finished_o,
  output logic [1:0]  job_level_o,
  output logic [1:0]  scan_level_out_o,
  output logic [4:0]  queue_count_o
);
  import mlfq_pkg::*;

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LvlW = $clog2(TOP_LEVEL + 1);
  localparam int unsigned EntW = 8 + 2 + 16 + 7 + LvlW;
  localparam logic [LvlW-1:0] TopLvl = LvlW'(TOP_LEVEL);
  localparam logic [CntW-1:0] Depth  = CntW'(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0]      tag;
    logic [1:0]      typ;
    logic [15:0]     len;
    logic [6:0]      odds;
    logic [LvlW-1:0] lvl;
  } entry_t;

  state_e state_q, state_d;

  // queue memory
  logic [EntW-1:0] mem [QUEUE_DEPTH];
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata;
  entry_t          rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= entry_t'(mem[mem_raddr]);
  end

  // control registers
  logic [15:0]     quantum_q, allot_q;
  logic [CntW-1:0] count_q, count_d;
  logic [LvlW-1:0] scan_q, scan_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic            rd_pend_q, rd_pend_d;
  logic            found_q, found_d, higher_q, higher_d, multi_q, multi_d;
  logic [IdxW-1:0] pick_q, pick_d;
  entry_t          job_q, job_d;
  logic [15:0]     run_q, run_d;
  logic            fin_q, fin_d;
  logic [1:0]      cmd_q;
  logic [6:0]      roll_q;
  logic [15:0]     seed_q;
  entry_t          new_q;
  logic [2:0]      stat_q, stat_d;
  logic            mod_go_q, mod_go_d;
  mod_req_t        mreq;
  mod_rsp_t        mrsp;

  mlfq_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign mreq.start    = mod_go_q;
  assign mreq.dividend = seed_q;
  assign mreq.divisor  = {1'b0, run_q} + 17'd1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumReset;
      allot_q   <= AllotmentReset;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_QUANTUM:   quantum_q <= cfg_data_i;
        REG_ALLOTMENT: allot_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (cmd_e'(command_i))
            CMD_ADD:      state_d = S_WRITE;
            CMD_DISPATCH: state_d = S_SCAN;
            CMD_BOOST:    state_d = S_BOOST;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (ptr_q >= count_q && !rd_pend_q) begin
          state_d = found_q ? S_READ : S_DONE;
        end
      end
      S_READ:   state_d = S_CHOOSE;
      S_CHOOSE: state_d = (roll_q <= rdata_q.odds) ? S_MOD : S_SUB;
      S_MOD:    state_d = mrsp.done ? S_SUB : S_MOD;
      S_SUB:    state_d = S_SHIFT;
      S_SHIFT: begin
        if (fin_q) begin
          if (ptr_q + CntW'(1) >= count_q && !rd_pend_q) state_d = S_DONE;
        end else if (ptr_q == '0 && !rd_pend_q) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: state_d = S_DONE;
      S_BOOST: if (ptr_q >= count_q) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d   = count_q;
    scan_d    = scan_q;
    ptr_d     = ptr_q;
    rd_pend_d = 1'b0;
    found_d   = found_q;
    higher_d  = higher_q;
    multi_d   = multi_q;
    pick_d    = pick_q;
    job_d     = job_q;
    run_d     = run_q;
    fin_d     = fin_q;
    stat_d    = stat_q;
    mod_go_d  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = ptr_q[IdxW-1:0];
    case (state_q)
      S_IDLE: begin
        ptr_d    = '0;
        found_d  = 1'b0;
        higher_d = 1'b0;
        multi_d  = 1'b0;
        fin_d    = 1'b0;
        run_d    = '0;
        stat_d   = ST_NOTHING;
        job_d    = '0;
      end
      S_SCAN: begin
        // one entry read a cycle, compared the cycle after
        if (ptr_q < count_q) begin
          ptr_d     = ptr_q + CntW'(1);
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          if (rdata_q.lvl > scan_q) higher_d = 1'b1;
          if (rdata_q.lvl == scan_q) begin
            if (!found_q) pick_d = IdxW'(ptr_q - CntW'(1));
            else          multi_d = 1'b1;
            found_d = 1'b1;
          end
        end
        if (ptr_q >= count_q && !rd_pend_q && !found_q) begin
          if (higher_q && scan_q < TopLvl) scan_d = scan_q + LvlW'(1);
          else if (scan_q != '0)           scan_d = scan_q - LvlW'(1);
        end
        mem_raddr = ptr_q[IdxW-1:0];
      end
      S_READ: begin
        mem_raddr = pick_q;
      end
      S_CHOOSE: begin
        job_d = rdata_q;
        if (rdata_q.len < quantum_q) begin
          run_d = rdata_q.len;
        end else if (multi_q) begin
          run_d = quantum_q;
        end else begin
          run_d = allot_q;
          if (rdata_q.lvl != '0) job_d.lvl = rdata_q.lvl - LvlW'(1);
        end
        mod_go_d = (roll_q <= rdata_q.odds);
      end
      S_MOD: begin
        if (mrsp.done) run_d = mrsp.rem;
      end
      S_SUB: begin
        fin_d     = run_q >= job_q.len;
        job_d.len = (run_q >= job_q.len) ? 16'd0 : job_q.len - run_q;
        ptr_d     = CntW'(pick_q);
        stat_d    = ST_DISPATCH;
      end
      S_SHIFT: begin
        if (fin_q) begin
          // close the gap: entry i+1 moves to i
          mem_raddr = IdxW'(ptr_q + CntW'(1));
          if (!rd_pend_q && ptr_q + CntW'(1) < count_q) begin
            rd_pend_d = 1'b1;
          end
          if (rd_pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = ptr_q[IdxW-1:0];
            mem_wdata = rdata_q;
            ptr_d     = ptr_q + CntW'(1);
          end
          if (ptr_q + CntW'(1) >= count_q && !rd_pend_q) count_d = count_q - CntW'(1);
        end else begin
          // open the head: entry i-1 moves to i
          mem_raddr = IdxW'(ptr_q - CntW'(1));
          if (!rd_pend_q && ptr_q != '0) rd_pend_d = 1'b1;
          if (rd_pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = ptr_q[IdxW-1:0];
            mem_wdata = rdata_q;
            ptr_d     = ptr_q - CntW'(1);
          end
        end
      end
      S_WRITE: begin
        if (cmd_q == CMD_ADD) begin
          if (count_q >= Depth) begin
            stat_d = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = count_q[IdxW-1:0];
            mem_wdata = new_q;
            count_d   = count_q + CntW'(1);
            stat_d    = ST_ADDED;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = job_q;
        end
      end
      S_BOOST: begin
        // read-modify-write of one entry: the read, then the write at the top level
        stat_d = ST_BOOSTED;
        if (ptr_q < count_q) begin
          if (!rd_pend_q) begin
            rd_pend_d = 1'b1;
          end else begin
            mem_we        = 1'b1;
            mem_waddr     = ptr_q[IdxW-1:0];
            mem_wdata     = rdata_q;
            mem_wdata[LvlW-1:0] = TopLvl;
            ptr_d         = ptr_q + CntW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      scan_q    <= TopLvl;
      ptr_q     <= '0;
      rd_pend_q <= 1'b0;
      mod_go_q  <= 1'b0;
      found_q   <= 1'b0;
      higher_q  <= 1'b0;
      multi_q   <= 1'b0;
      fin_q     <= 1'b0;
      stat_q    <= ST_NOTHING;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      ptr_q     <= ptr_d;
      rd_pend_q <= rd_pend_d;
      mod_go_q  <= mod_go_d;
      found_q   <= found_d;
      higher_q  <= higher_d;
      multi_q   <= multi_d;
      fin_q     <= fin_d;
      stat_q    <= stat_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    pick_q <= pick_d;
    job_q  <= job_d;
    run_q  <= run_d;
    if (state_q == S_IDLE && start_i) begin
      cmd_q         <= command_i;
      roll_q        <= io_roll_i;
      seed_q        <= io_seed_i;
      new_q.tag     <= job_tag_i;
      new_q.typ     <= job_type_i;
      new_q.len     <= job_length_i;
      new_q.odds    <= io_odds_i;
      new_q.lvl     <= TopLvl;
    end
  end

  // outputs
  logic disp;
  always_comb begin
    disp             = (stat_q == ST_DISPATCH);
    busy_o           = (state_q != S_IDLE);
    done_o           = (state_q == S_DONE);
    status_o         = stat_q;
    out_tag_o        = disp ? job_q.tag : 8'd0;
    out_type_o       = disp ? job_q.typ : 2'd0;
    run_time_o       = disp ? run_q : 16'd0;
    remaining_o      = disp ? job_q.len : 16'd0;
    finished_o       = disp & fin_q;
    job_level_o      = disp ? 2'(job_q.lvl) : 2'd0;
    scan_level_out_o = 2'(scan_q);
    queue_count_o    = 5'(count_q);
  end

endmodule
